// ===== src/cca_pkg.sv =====
// ----------------------------------------------------------------------------
// cca_pkg: shared types and control program for the collision centroid block
// Holds the table geometry, the transaction and result payloads, the table
// entry layout and the read-only control program of the sequencer.
// ----------------------------------------------------------------------------
package cca_pkg;

    // Table geometry and field widths
    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EIDX_W   = 4;
    localparam int COUNT_W  = 24;
    localparam int SUM_W    = 40;
    localparam int POLY_W   = 8;
    localparam int COORD_W  = 8;
    localparam int DX_W     = 17;
    localparam int DY_W     = 16;
    localparam int ITER_W   = $clog2(SUM_W + 1);

    // Function codes of an input transaction
    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_SLICE = 2'd1,
        FUNC_FINAL = 2'd2,
        FUNC_NONE  = 2'd3
    } cca_func_t;

    typedef struct packed {
        cca_func_t            func;
        logic [EIDX_W-1:0]    entry_a;
        logic [EIDX_W-1:0]    entry_b;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   x_start;
        logic [COORD_W-1:0]   x_end;
        logic [POLY_W-1:0]    poly_a;
        logic [POLY_W-1:0]    poly_b;
    } cca_cmd_t;

    typedef struct packed {
        logic [EIDX_W-1:0]    entry_index;
        logic [COUNT_W-1:0]   pixel_count;
        logic [SUM_W-1:0]     center_x;
        logic [SUM_W-1:0]     center_y;
        logic [POLY_W-1:0]    partner;
        logic                 last_entry;
    } cca_result_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [COUNT_W-1:0]   count;
        logic [SUM_W-1:0]     sum_x;
        logic [SUM_W-1:0]     sum_y;
        logic [POLY_W-1:0]    partner;
    } cca_entry_t;

    // Control word fields
    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_A    = 2'd1,
        RD_B    = 2'd2,
        RD_K    = 2'd3
    } cca_rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_A    = 2'd1,
        WR_B    = 2'd2,
        WR_K    = 2'd3
    } cca_wr_sel_t;

    typedef enum logic [1:0] {
        SEQ_DISPATCH = 2'd0,
        SEQ_NEXT     = 2'd1,
        SEQ_IDLE     = 2'd2,
        SEQ_LOOP     = 2'd3
    } cca_seq_t;

    typedef struct packed {
        cca_rd_sel_t  rd_sel;
        cca_wr_sel_t  wr_sel;
        logic         div_go;
        logic         wait_div;
        logic         emit;
        cca_seq_t     seq;
    } cca_ctrl_t;

    // Program addresses
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
    localparam logic [PC_W-1:0] PC_SL_RDA = 3'd1;
    localparam logic [PC_W-1:0] PC_SL_WRA = 3'd2;
    localparam logic [PC_W-1:0] PC_SL_WRB = 3'd3;
    localparam logic [PC_W-1:0] PC_FN_RD  = 3'd4;
    localparam logic [PC_W-1:0] PC_FN_DIV = 3'd5;
    localparam logic [PC_W-1:0] PC_FN_WB  = 3'd6;

    // Control program: one word per step
    function automatic cca_ctrl_t ucode(input logic [PC_W-1:0] pc);
        cca_ctrl_t c;
        c = '{rd_sel: RD_NONE, wr_sel: WR_NONE, div_go: 1'b0, wait_div: 1'b0,
              emit: 1'b0, seq: SEQ_IDLE};
        unique case (pc)
            PC_IDLE:   c.seq = SEQ_DISPATCH;
            PC_SL_RDA: begin
                c.rd_sel = RD_A;
                c.seq    = SEQ_NEXT;
            end
            PC_SL_WRA: begin
                c.rd_sel = RD_B;
                c.wr_sel = WR_A;
                c.seq    = SEQ_NEXT;
            end
            PC_SL_WRB: begin
                c.wr_sel = WR_B;
                c.seq    = SEQ_IDLE;
            end
            PC_FN_RD:  begin
                c.rd_sel = RD_K;
                c.seq    = SEQ_NEXT;
            end
            PC_FN_DIV: begin
                c.div_go = 1'b1;
                c.seq    = SEQ_NEXT;
            end
            PC_FN_WB:  begin
                c.wr_sel   = WR_K;
                c.wait_div = 1'b1;
                c.emit     = 1'b1;
                c.seq      = SEQ_LOOP;
            end
            default:   c.seq = SEQ_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== src/cca_ram.sv =====
// ----------------------------------------------------------------------------
// cca_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module cca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/cca_div.sv =====
// ----------------------------------------------------------------------------
// cca_div: dual restoring divider with a shared divisor
// Divides the x and y sums by the pixel count, one quotient bit per cycle
// for each of the two dividends.
// ----------------------------------------------------------------------------
module cca_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cca_pkg::SUM_W-1:0]    dividend_x,
    input  logic [cca_pkg::SUM_W-1:0]    dividend_y,
    input  logic [cca_pkg::COUNT_W-1:0]  divisor,
    output logic                         busy,
    output logic [cca_pkg::SUM_W-1:0]    quot_x,
    output logic [cca_pkg::SUM_W-1:0]    quot_y
);
    import cca_pkg::*;

    logic [ITER_W-1:0]   iter_reg;
    logic [SUM_W-1:0]    qx_reg;
    logic [SUM_W-1:0]    qy_reg;
    logic [COUNT_W-1:0]  rx_reg;
    logic [COUNT_W-1:0]  ry_reg;
    logic [COUNT_W-1:0]  dvs_reg;
    logic [COUNT_W:0]    stx;
    logic [COUNT_W:0]    sty;

    // One restoring step: returns {quotient bit, new remainder}
    function automatic logic [COUNT_W:0] div_step(input logic [COUNT_W-1:0] rem,
                                                  input logic               msb,
                                                  input logic [COUNT_W-1:0] dvs);
        logic [COUNT_W:0] sh;
        logic [COUNT_W:0] diff;
        sh   = {rem, msb};
        diff = sh - {1'b0, dvs};
        if (sh >= {1'b0, dvs})
        begin
            return {1'b1, diff[COUNT_W-1:0]};
        end
        return {1'b0, sh[COUNT_W-1:0]};
    endfunction

    assign stx = div_step(rx_reg, qx_reg[SUM_W-1], dvs_reg);
    assign sty = div_step(ry_reg, qy_reg[SUM_W-1], dvs_reg);

    // Count the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (start)
        begin
            iter_reg <= ITER_W'(SUM_W);
        end
        else if (busy)
        begin
            iter_reg <= iter_reg - ITER_W'(1);
        end
    end

    // Shift quotient bits in, keep the partial remainders
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qx_reg  <= dividend_x;
            qy_reg  <= dividend_y;
            rx_reg  <= '0;
            ry_reg  <= '0;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            qx_reg <= {qx_reg[SUM_W-2:0], stx[COUNT_W]};
            qy_reg <= {qy_reg[SUM_W-2:0], sty[COUNT_W]};
            rx_reg <= stx[COUNT_W-1:0];
            ry_reg <= sty[COUNT_W-1:0];
        end
    end

    assign busy   = (iter_reg != '0);
    assign quot_x = qx_reg;
    assign quot_y = qy_reg;

endmodule

// ===== src/collision_centroid_accumulator.sv =====
// ----------------------------------------------------------------------------
// collision_centroid_accumulator: per-entry overlap centroids
// Accumulates overlapping spans into a table of collision entries and turns
// the sums into centroids at frame end, reporting every entry.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction on cmd is taken at a rising edge with start high and busy
//   low. Clear (frame start) leaves busy low. A slice keeps busy high while
//   it does one RAM read-modify-write for each of the two named entries.
//   Finalize walks the table. Each entry runs 3 sequencer steps (read,
//   divide, write back); an entry with a nonzero count also waits for the
//   bit-serial divider, and an entry with a zero count skips the divider.
//   Each reported entry appears on result for one cycle with result_valid
//   high, in index order, the final one marked by last_entry. The receiver
//   cannot hold results off, and none are ever dropped.
//   Reset clears the table (per-entry valid bits) and the sequencer, and the
//   block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module collision_centroid_accumulator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cca_pkg::cca_cmd_t     cmd,
    output logic                  result_valid,
    output cca_pkg::cca_result_t  result
);
    import cca_pkg::*;

    // Sequencer state
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [IDX_W-1:0]    rd_addr_reg;
    logic                out_valid_reg, out_valid_next;

    // Held transaction and span terms
    cca_cmd_t            cmd_reg;
    logic [COORD_W-1:0]  len_reg;
    logic [DX_W-1:0]     dx_reg;
    logic [DY_W-1:0]     dy_reg;
    cca_entry_t          rec_reg;
    cca_entry_t          fwd_reg;
    cca_result_t         out_reg, out_next;

    cca_ctrl_t           ctrl;
    logic                accept;
    logic                stall;
    logic                k_last;
    logic [COORD_W-1:0]  len;
    logic [DY_W-1:0]     xl;
    logic [DX_W-1:0]     tri_w;
    logic [IDX_W-1:0]    addr_a, addr_b;
    logic                in_a, in_b;
    logic [IDX_W-1:0]    raddr;
    cca_entry_t          rdata, rd_rec, b_src;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    cca_entry_t          wdata;
    logic                div_start, div_busy;
    logic [SUM_W-1:0]    quot_x, quot_y;
    logic [SUM_W-1:0]    fin_x, fin_y;

    // Add one span to an entry
    function automatic cca_entry_t add_span(input cca_entry_t e,
                                            input logic [COORD_W-1:0] l,
                                            input logic [DX_W-1:0] dx,
                                            input logic [DY_W-1:0] dy,
                                            input logic [POLY_W-1:0] other);
        cca_entry_t r;
        r.count   = e.count + COUNT_W'(l);
        r.sum_x   = e.sum_x + SUM_W'(dx);
        r.sum_y   = e.sum_y + SUM_W'(dy);
        r.partner = other;
        return r;
    endfunction

    // Span terms from the incoming transaction
    assign len   = (cmd.x_end >= cmd.x_start) ? (cmd.x_end - cmd.x_start) : '0;
    assign xl    = DY_W'(cmd.x_start) * DY_W'(len);
    assign tri_w = (DX_W'(len) + DX_W'(1)) * DX_W'(len);

    assign accept = start && !busy;
    assign busy   = (pc_reg != PC_IDLE);
    assign ctrl   = ucode(pc_reg);
    assign stall  = ctrl.wait_div && div_busy;
    assign k_last = (k_reg == IDX_W'(ENTRIES - 1));

    assign addr_a = IDX_W'(cmd_reg.entry_a);
    assign addr_b = IDX_W'(cmd_reg.entry_b);
    assign in_a   = (32'(cmd_reg.entry_a) < ENTRIES);
    assign in_b   = (32'(cmd_reg.entry_b) < ENTRIES);

    // Select the read address
    always_comb
    begin
        unique case (ctrl.rd_sel)
            RD_A:    raddr = addr_a;
            RD_B:    raddr = addr_b;
            RD_K:    raddr = k_reg;
            default: raddr = rd_addr_reg;
        endcase
    end

    // Entries never written since the last clear read as zero
    assign rd_rec = valid_reg[rd_addr_reg] ? rdata : '0;
    assign b_src  = (cmd_reg.entry_b == cmd_reg.entry_a) ? fwd_reg : rd_rec;

    // Finalized centroids, left alone when the count is zero
    assign fin_x = (rec_reg.count != '0) ? quot_x : rec_reg.sum_x;
    assign fin_y = (rec_reg.count != '0) ? quot_y : rec_reg.sum_y;

    // Select the write port
    always_comb
    begin
        we    = 1'b0;
        waddr = k_reg;
        wdata = add_span(rd_rec, len_reg, dx_reg, dy_reg, cmd_reg.poly_b);
        unique case (ctrl.wr_sel)
            WR_A:
            begin
                we    = in_a;
                waddr = addr_a;
            end
            WR_B:
            begin
                we    = in_b;
                waddr = addr_b;
                wdata = add_span(b_src, len_reg, dx_reg, dy_reg, cmd_reg.poly_a);
            end
            WR_K:
            begin
                we    = !stall;
                waddr = k_reg;
                wdata = '{count: rec_reg.count, sum_x: fin_x, sum_y: fin_y,
                          partner: rec_reg.partner};
            end
            default: we = 1'b0;
        endcase
    end

    assign div_start = ctrl.div_go && (rd_rec.count != '0);

    // Advance the program
    always_comb
    begin
        pc_next        = pc_reg;
        k_next         = k_reg;
        valid_next     = valid_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
        if (ctrl.emit && !stall)
        begin
            out_valid_next       = 1'b1;
            out_next.entry_index = EIDX_W'(k_reg);
            out_next.pixel_count = rec_reg.count;
            out_next.center_x    = fin_x;
            out_next.center_y    = fin_y;
            out_next.partner     = rec_reg.partner;
            out_next.last_entry  = k_last;
        end
        unique case (ctrl.seq)
            SEQ_DISPATCH:
            begin
                if (accept)
                begin
                    unique case (cmd.func)
                        FUNC_CLEAR: valid_next = '0;
                        FUNC_SLICE: pc_next = PC_SL_RDA;
                        FUNC_FINAL:
                        begin
                            pc_next = PC_FN_RD;
                            k_next  = '0;
                        end
                        default:    pc_next = PC_IDLE;
                    endcase
                end
            end
            SEQ_NEXT: pc_next = pc_reg + PC_W'(1);
            SEQ_IDLE: pc_next = PC_IDLE;
            default:
            begin
                if (!stall)
                begin
                    if (k_last)
                    begin
                        pc_next = PC_IDLE;
                        k_next  = '0;
                    end
                    else
                    begin
                        pc_next = PC_FN_RD;
                        k_next  = k_reg + IDX_W'(1);
                    end
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            k_reg         <= '0;
            valid_reg     <= '0;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            k_reg         <= k_next;
            valid_reg     <= valid_next;
            rd_addr_reg   <= raddr;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            len_reg <= len;
            dx_reg  <= DX_W'(xl) + (tri_w >> 1);
            dy_reg  <= DY_W'(len) * DY_W'(cmd.row);
        end
        if (ctrl.wr_sel == WR_A)
        begin
            fwd_reg <= wdata;
        end
        if (ctrl.div_go)
        begin
            rec_reg <= rd_rec;
        end
        out_reg <= out_next;
    end

    cca_ram #(
        .WIDTH ($bits(cca_entry_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    cca_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend_x (rd_rec.sum_x),
        .dividend_y (rd_rec.sum_y),
        .divisor    (rd_rec.count),
        .busy       (div_busy),
        .quot_x     (quot_x),
        .quot_y     (quot_y)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== sim/cca_checker.sv =====
// ----------------------------------------------------------------------------
// cca_checker: centroid table predictor and result checker
// Watches the command and result channels of the collision centroid block,
// keeps its own copy of the collision table, works out the entry reports
// that each finalize transaction causes and compares every reported entry,
// field by field, with the oldest report still owed.
// ----------------------------------------------------------------------------
module cca_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  cca_pkg::cca_cmd_t     cmd,
    input  logic                  result_valid,
    input  cca_pkg::cca_result_t  result,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cca_pkg::*;

    // Shadow copy of the collision table
    logic [COUNT_W-1:0] hit_tbl     [ENTRIES];
    logic [SUM_W-1:0]   sumx_tbl    [ENTRIES];
    logic [SUM_W-1:0]   sumy_tbl    [ENTRIES];
    logic [POLY_W-1:0]  partner_tbl [ENTRIES];

    // Entry reports owed by the block, oldest first
    cca_result_t entry_reports_q[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic clear_table();
        for (int k = 0; k < ENTRIES; k++)
        begin
            hit_tbl[k]     = '0;
            sumx_tbl[k]    = '0;
            sumy_tbl[k]    = '0;
            partner_tbl[k] = '0;
        end
    endtask

    // Add one overlapping span to both named entries, entry_a first
    task automatic accumulate_span(input cca_cmd_t c);
        logic [SUM_W-1:0] xs, xe, span_len, x_add, y_add;
        xs       = c.x_start;
        xe       = c.x_end;
        span_len = (xe >= xs) ? (xe - xs) : '0;
        x_add    = xs * span_len + ((span_len + 1) * span_len) / 2;
        y_add    = span_len * SUM_W'(c.row);
        if (c.entry_a < ENTRIES)
        begin
            hit_tbl[c.entry_a]     = hit_tbl[c.entry_a] + span_len[COUNT_W-1:0];
            sumx_tbl[c.entry_a]    = sumx_tbl[c.entry_a] + x_add;
            sumy_tbl[c.entry_a]    = sumy_tbl[c.entry_a] + y_add;
            partner_tbl[c.entry_a] = c.poly_b;
        end
        if (c.entry_b < ENTRIES)
        begin
            hit_tbl[c.entry_b]     = hit_tbl[c.entry_b] + span_len[COUNT_W-1:0];
            sumx_tbl[c.entry_b]    = sumx_tbl[c.entry_b] + x_add;
            sumy_tbl[c.entry_b]    = sumy_tbl[c.entry_b] + y_add;
            partner_tbl[c.entry_b] = c.poly_a;
        end
    endtask

    // Divide nonzero entries in place and queue one report per entry
    task automatic finalize_centroids();
        cca_result_t r;
        logic [SUM_W-1:0] divisor;
        for (int k = 0; k < ENTRIES; k++)
        begin
            divisor = hit_tbl[k];
            if (divisor != 0)
            begin
                sumx_tbl[k] = sumx_tbl[k] / divisor;
                sumy_tbl[k] = sumy_tbl[k] / divisor;
            end
            r.entry_index = EIDX_W'(k);
            r.pixel_count = hit_tbl[k];
            r.center_x    = sumx_tbl[k];
            r.center_y    = sumy_tbl[k];
            r.partner     = partner_tbl[k];
            r.last_entry  = (k == ENTRIES - 1);
            entry_reports_q.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] exp_v,
                               input logic [SUM_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            entry_reports_q.delete();
            pending = 0;
        end
        else
        begin
            // Compare a reported entry with the oldest one owed
            if (result_valid)
            begin
                if (entry_reports_q.size() == 0)
                begin
                    $display("%0t: unexpected entry report: expected none, got %p",
                             $time, result);
                    fail_count++;
                end
                else
                begin
                    cca_result_t want;
                    want = entry_reports_q.pop_front();
                    check_field("entry_index", want.entry_index, result.entry_index);
                    check_field("pixel_count", want.pixel_count, result.pixel_count);
                    check_field("center_x", want.center_x, result.center_x);
                    check_field("center_y", want.center_y, result.center_y);
                    check_field("partner", want.partner, result.partner);
                    check_field("last_entry", want.last_entry, result.last_entry);
                end
            end
            // Advance the table on each accepted transaction
            if (start && !busy)
            begin
                case (cmd.func)
                    FUNC_CLEAR: clear_table();
                    FUNC_SLICE: accumulate_span(cmd);
                    FUNC_FINAL: finalize_centroids();
                    default:    ;
                endcase
            end
            pending = entry_reports_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: collision centroid accumulator
// Drives clear, slice and finalize transactions: a directed set covering the
// span extremes, reversed and empty spans, one entry named twice, the unused
// function code and repeated finalize, then random frames under changing
// sender gaps, and a short run that piles full-width spans onto one entry.
// A checker beside the block predicts and compares every reported entry.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cca_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 100;
    localparam int CMD_W = $bits(cca_cmd_t);

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    cca_cmd_t    cmd = '0;
    logic        result_valid;
    cca_result_t result;
    int          fail_count;
    int          pending;
    int          sent_count = 0;
    int          idle_pct = 0;
    int          stall_cycles = 0;

    collision_centroid_accumulator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    cca_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // End the run when nothing is accepted or reported for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("[collision_centroid_accumulator] ERROR");
            $finish;
        end
    end

    function automatic cca_cmd_t make_cmd(input cca_func_t f, input int ea, input int eb,
                                          input int row, input int xs, input int xe,
                                          input int pa, input int pb);
        cca_cmd_t c;
        c.func    = f;
        c.entry_a = EIDX_W'(ea);
        c.entry_b = EIDX_W'(eb);
        c.row     = COORD_W'(row);
        c.x_start = COORD_W'(xs);
        c.x_end   = COORD_W'(xe);
        c.poly_a  = POLY_W'(pa);
        c.poly_b  = POLY_W'(pb);
        return c;
    endfunction

    // Random bits in every field, function code forced
    function automatic cca_cmd_t noise_cmd(input cca_func_t f);
        logic [CMD_W-1:0] raw;
        cca_cmd_t c;
        raw = CMD_W'({$urandom, $urandom});
        c = raw;
        c.func = f;
        return c;
    endfunction

    // Mostly forward spans, some empty, some reversed
    function automatic cca_cmd_t random_slice();
        cca_cmd_t c;
        int pick;
        c = noise_cmd(FUNC_SLICE);
        pick = $urandom_range(99);
        if (pick < 75)
            c.x_end = COORD_W'($urandom_range(255, c.x_start));
        else if (pick < 85)
            c.x_end = c.x_start;
        return c;
    endfunction

    // Offer one transaction after random gaps; return at the next falling edge
    task automatic send_cmd(input cca_cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        sent_count++;
        @(negedge clk);
    endtask

    // Hold off until every owed entry report has come
    task automatic hold_until_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Well-formed frames with random content and some noise
    task automatic run_frames(input int n_items);
        int target;
        target = sent_count + n_items;
        while (sent_count < target)
        begin
            if ($urandom_range(9) != 0)
                send_cmd(noise_cmd(FUNC_CLEAR));
            repeat ($urandom_range(1, 12))
            begin
                send_cmd(random_slice());
                if ($urandom_range(19) == 0)
                    send_cmd(noise_cmd(FUNC_NONE));
            end
            send_cmd(noise_cmd(FUNC_FINAL));
            if ($urandom_range(6) == 0)
                send_cmd(noise_cmd(FUNC_FINAL));
            if ($urandom_range(3) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        cca_cmd_t c;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: span extremes, partners, special cases
        idle_pct = 32;
        send_cmd(make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_SLICE, 0, 15, 0, 0, 255, 255, 0));
        send_cmd(make_cmd(FUNC_SLICE, 15, 0, 255, 255, 255, 0, 255));
        send_cmd(make_cmd(FUNC_SLICE, 7, 7, 255, 0, 255, 8'hAA, 8'h55));
        send_cmd(make_cmd(FUNC_SLICE, 3, 4, 99, 200, 10, 1, 2));
        send_cmd(make_cmd(FUNC_SLICE, 3, 4, 128, 17, 99, 3, 4));
        send_cmd(make_cmd(FUNC_SLICE, 9, 10, 1, 254, 255, 12, 200));
        send_cmd(make_cmd(FUNC_NONE, 15, 15, 255, 0, 255, 255, 255));
        send_cmd(make_cmd(FUNC_FINAL, 0, 0, 0, 0, 0, 0, 0));
        hold_until_drained();
        send_cmd(make_cmd(FUNC_FINAL, 15, 15, 255, 255, 255, 255, 255));
        send_cmd(make_cmd(FUNC_SLICE, 0, 1, 77, 3, 250, 21, 43));
        send_cmd(make_cmd(FUNC_FINAL, 5, 6, 1, 2, 3, 4, 5));
        send_cmd(make_cmd(FUNC_CLEAR, 15, 15, 255, 255, 255, 255, 255));
        send_cmd(make_cmd(FUNC_FINAL, 0, 0, 0, 0, 0, 0, 0));
        hold_until_drained();

        // Random frames under three gap settings
        run_frames(48);
        idle_pct = 68;
        run_frames(48);
        idle_pct = 0;
        run_frames(48);

        // Pile full-width spans onto one entry, named twice per slice
        send_cmd(noise_cmd(FUNC_CLEAR));
        repeat (6)
        begin
            c = random_slice();
            c.entry_a = 4'd5;
            c.entry_b = 4'd5;
            c.x_start = '0;
            c.x_end   = '1;
            send_cmd(c);
        end
        repeat (4) send_cmd(random_slice());
        send_cmd(noise_cmd(FUNC_FINAL));

        // Drain and settle, then give the verdict
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[collision_centroid_accumulator] OK");
        else
            $display("[collision_centroid_accumulator] ERROR");
        $finish;
    end

endmodule
